// ===== design/sgr_pkg.sv =====
// Shared types, codes and helpers for the stick gesture recognizer.
`default_nettype none
package sgr_pkg;

	// Most sequence steps a gesture may use; step words are stored for four.
	localparam int MAX_STEPS  = 4;
	localparam int STEP_WORDS = 4;
	localparam int STEP_CAP   = (MAX_STEPS < STEP_WORDS) ? MAX_STEPS : STEP_WORDS;

	localparam int STEP_W   = 52;
	localparam int TIMER_W  = 16;
	localparam int ANGLE_W  = 9;
	localparam int DEG_W    = 16;
	localparam int REG_IDX_W = 3;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_STEP_0     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_STEP_1     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_STEP_2     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_STEP_3     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_STEP_COUNT = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_RESET_POS  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_MIN_RADIUS = 3'd7;

	// gesture modes
	localparam logic [1:0] MODE_SEQ = 2'd0;
	localparam logic [1:0] MODE_CW  = 2'd1;
	localparam logic [1:0] MODE_CCW = 2'd2;

	// axis test codes
	localparam logic [1:0] DIR_WINDOW = 2'd0;
	localparam logic [1:0] DIR_LOW    = 2'd1;
	localparam logic [1:0] DIR_HIGH   = 2'd2;
	localparam logic [1:0] DIR_NEVER  = 2'd3;

	// wrap thresholds for rotation tracking
	localparam logic [ANGLE_W-1:0] WRAP_HIGH = 9'd300;
	localparam logic [ANGLE_W-1:0] WRAP_LOW  = 9'd60;

	// reset values
	localparam logic [2:0]        STEP_COUNT_RST = 3'd4;
	localparam logic signed [7:0] RESET_POS_RST  = -8'sd15;
	localparam logic [7:0]        MIN_RADIUS_RST = 8'd70;

	typedef struct packed {
		logic [TIMER_W-1:0] limit;
		logic [1:0]         y_dir;
		logic [1:0]         x_dir;
		logic signed [7:0]  y_second;
		logic signed [7:0]  y_first;
		logic signed [7:0]  x_second;
		logic signed [7:0]  x_first;
	} step_t;

	typedef struct packed {
		logic seq_en;
		logic rot_en;
		logic clockwise;
		logic restart;
	} cmd_t;

	function automatic logic axis_ok(input logic signed [7:0] pos,
	                                 input logic signed [7:0] first,
	                                 input logic signed [7:0] second,
	                                 input logic [1:0] dir);
		logic r;
		case (dir)
			DIR_WINDOW: r = (pos > first) && (pos < second);
			DIR_LOW:    r = pos < first;
			DIR_HIGH:   r = pos > first;
			default:    r = 1'b0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/stick_gesture_recognizer.sv =====
// Stick gesture recognizer top level: channels, configuration and status result.
//
// Usage: one stick sample enters per item on the s_ channel; exactly one status
// item leaves on the m_ channel for each sample, in order.
// The s_ side captures the sample into an input register. When that register
// holds an item and the result register is free or being emptied, the sample
// is matched against the state and the new state becomes the result. A sample
// passes the input register and then the state registers, which form the result;
// a new sample is accepted every cycle while m_tready stays high, so throughput
// is one item per cycle, set by the single state update per sample.
// When m_tready is low, the finished result holds on m_tdata, one more sample
// waits in the input register and s_tready then drops until the result is taken.
// Reset (arst_n low) clears all tracking state and both valid flags and loads
// the register defaults: four steps, reset position -15, sequence mode,
// radius threshold 70, step words zero. Configuration is written by the user
// through cfg_we/cfg_index/cfg_data while idle; the block does not enforce it.
`default_nettype none
module stick_gesture_recognizer (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [sgr_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [sgr_pkg::STEP_W-1:0]   cfg_data,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// x_pos[7:0], y_pos[15:8], stick_angle[24:16], stick_radius[32:25], zero[39:33]
	input  wire logic [39:0]                  s_tdata,
	// restart[0]
	input  wire logic                         s_tuser,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// step_index[2:0], complete[3], moving[4], rotating[5], degrees_turned[21:6],
	// zero[23:22]
	output logic [23:0]                       m_tdata
);

	sgr_pkg::step_t [sgr_pkg::STEP_WORDS-1:0] step_q;
	logic [2:0]                step_count_q;
	logic signed [7:0]         reset_pos_q;
	logic [1:0]                mode_q;
	logic [7:0]                min_radius_q;

	logic                          valid_s1;
	logic signed [7:0]             x_s1, y_s1;
	logic [sgr_pkg::ANGLE_W-1:0]   angle_s1;
	logic [7:0]                    radius_s1;
	logic                          restart_s1;
	logic                          m_valid_q;
	logic                          advance;
	sgr_pkg::cmd_t                 cmd;

	logic [2:0]                    step_index;
	logic                          complete, moving, rotating;
	logic [sgr_pkg::DEG_W-1:0]     degrees_turned;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= '0;
			step_count_q <= sgr_pkg::STEP_COUNT_RST;
			reset_pos_q  <= sgr_pkg::RESET_POS_RST;
			mode_q       <= sgr_pkg::MODE_SEQ;
			min_radius_q <= sgr_pkg::MIN_RADIUS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				sgr_pkg::REG_STEP_0, sgr_pkg::REG_STEP_1,
				sgr_pkg::REG_STEP_2, sgr_pkg::REG_STEP_3:
					step_q[cfg_index[1:0]] <= cfg_data;
				sgr_pkg::REG_STEP_COUNT: step_count_q <= cfg_data[2:0];
				sgr_pkg::REG_RESET_POS:  reset_pos_q  <= $signed(cfg_data[7:0]);
				sgr_pkg::REG_MODE:       mode_q       <= cfg_data[1:0];
				sgr_pkg::REG_MIN_RADIUS: min_radius_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// process the held sample when the result register is free or draining
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			x_s1       <= $signed(s_tdata[7:0]);
			y_s1       <= $signed(s_tdata[15:8]);
			angle_s1   <= s_tdata[24:16];
			radius_s1  <= s_tdata[32:25];
			restart_s1 <= s_tuser;
		end
	end

	always_comb begin
		cmd.restart   = advance && restart_s1;
		cmd.seq_en    = advance && !restart_s1 && (mode_q == sgr_pkg::MODE_SEQ);
		cmd.rot_en    = advance && !restart_s1
		             && ((mode_q == sgr_pkg::MODE_CW) || (mode_q == sgr_pkg::MODE_CCW));
		cmd.clockwise = mode_q == sgr_pkg::MODE_CW;
	end

	sgr_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.steps      (step_q),
		.step_count (step_count_q),
		.reset_pos  (reset_pos_q),
		.x_pos      (x_s1),
		.y_pos      (y_s1),
		.step_index (step_index),
		.complete   (complete),
		.moving     (moving)
	);

	sgr_rot u_rot (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.min_radius     (min_radius_q),
		.stick_angle    (angle_s1),
		.stick_radius   (radius_s1),
		.rotating       (rotating),
		.degrees_turned (degrees_turned)
	);

	// state only moves when a result is loaded, so it doubles as the result register
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, degrees_turned, rotating, moving, complete, step_index};

endmodule
`default_nettype wire

// ===== design/sgr_seq.sv =====
// Step sequence matcher: attempt, step and timer state with its update logic.
`default_nettype none
module sgr_seq (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire sgr_pkg::cmd_t                         cmd,
	input  wire sgr_pkg::step_t [sgr_pkg::STEP_WORDS-1:0] steps,
	input  wire logic [2:0]                            step_count,
	input  wire logic signed [7:0]                     reset_pos,
	input  wire logic signed [7:0]                     x_pos,
	input  wire logic signed [7:0]                     y_pos,
	output logic [2:0]                                 step_index,
	output logic                                       complete,
	output logic                                       moving
);

	logic [sgr_pkg::TIMER_W-1:0] timer_q, timer_n, timer_inc;
	logic [2:0] steps_q, steps_n, steps_base, steps_next, cnt;
	logic       done_q, done_n, active_q, active_n;
	logic       pass, reset_hit;
	sgr_pkg::step_t cur, first;

	assign cnt = (step_count > 3'(sgr_pkg::STEP_CAP)) ? 3'(sgr_pkg::STEP_CAP) : step_count;

	always_comb begin
		steps_base = active_q ? steps_q : 3'd0;
		if (!active_q)
			timer_inc = '0;
		else if (timer_q != '1)
			timer_inc = timer_q + 1'b1;
		else
			timer_inc = timer_q;
		steps_next = steps_base + 3'd1;
		cur   = steps[steps_base[1:0]];
		first = steps[0];
		pass  = sgr_pkg::axis_ok(x_pos, cur.x_first, cur.x_second, cur.x_dir)
		     && sgr_pkg::axis_ok(y_pos, cur.y_first, cur.y_second, cur.y_dir)
		     && (timer_inc < cur.limit);
		// step 0 directions decide when the stick has fallen back
		case (first.x_dir)
			sgr_pkg::DIR_LOW:    reset_hit = x_pos > reset_pos;
			sgr_pkg::DIR_HIGH:   reset_hit = x_pos < reset_pos;
			sgr_pkg::DIR_WINDOW: begin
				case (first.y_dir)
					sgr_pkg::DIR_LOW:  reset_hit = y_pos > reset_pos;
					sgr_pkg::DIR_HIGH: reset_hit = y_pos < reset_pos;
					default:           reset_hit = 1'b0;
				endcase
			end
			default: reset_hit = 1'b0;
		endcase
	end

	always_comb begin
		timer_n  = timer_q;
		steps_n  = steps_q;
		done_n   = done_q;
		active_n = active_q;
		if (cmd.restart) begin
			steps_n  = 3'd0;
			done_n   = 1'b0;
			active_n = 1'b0;
		end else if (cmd.seq_en) begin
			timer_n  = timer_inc;
			active_n = 1'b1;
			if (steps_base >= cnt) begin
				steps_n = 3'd0;
			end else if (pass) begin
				timer_n = '0;
				steps_n = steps_next;
				if (steps_next >= cnt)
					done_n = 1'b1;
			end else begin
				steps_n = steps_base;
				if (reset_hit)
					active_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q  <= '0;
			steps_q  <= 3'd0;
			done_q   <= 1'b0;
			active_q <= 1'b0;
		end else begin
			timer_q  <= timer_n;
			steps_q  <= steps_n;
			done_q   <= done_n;
			active_q <= active_n;
		end
	end

	assign step_index = steps_q;
	assign complete   = done_q;
	assign moving     = active_q;

endmodule
`default_nettype wire

// ===== design/sgr_rot.sv =====
// Rotation tracker: last angle, running degree total and tracking flag.
`default_nettype none
module sgr_rot (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sgr_pkg::cmd_t                 cmd,
	input  wire logic [7:0]                    min_radius,
	input  wire logic [sgr_pkg::ANGLE_W-1:0]   stick_angle,
	input  wire logic [7:0]                    stick_radius,
	output logic                               rotating,
	output logic [sgr_pkg::DEG_W-1:0]          degrees_turned
);

	logic                          active_q, active_n;
	logic [sgr_pkg::ANGLE_W-1:0]   last_q, last_n, diff;
	logic [sgr_pkg::DEG_W-1:0]     total_q, total_n, total_add;
	logic [sgr_pkg::DEG_W:0]       sum;
	logic                          ahead, behind, wrap;

	always_comb begin
		ahead  = cmd.clockwise ? (stick_angle > last_q) : (stick_angle < last_q);
		behind = cmd.clockwise ? (stick_angle < last_q) : (stick_angle > last_q);
		wrap   = cmd.clockwise ? (last_q > sgr_pkg::WRAP_HIGH && stick_angle < sgr_pkg::WRAP_LOW)
		                       : (last_q < sgr_pkg::WRAP_LOW && stick_angle > sgr_pkg::WRAP_HIGH);
		diff   = cmd.clockwise ? (stick_angle - last_q) : (last_q - stick_angle);
		sum    = {1'b0, total_q} + (sgr_pkg::DEG_W+1)'(diff);
		// saturate the total
		total_add = sum[sgr_pkg::DEG_W] ? '1 : sum[sgr_pkg::DEG_W-1:0];
	end

	always_comb begin
		active_n = active_q;
		last_n   = last_q;
		total_n  = total_q;
		if (cmd.rot_en) begin
			if (stick_radius <= min_radius) begin
				active_n = 1'b0;
				total_n  = '0;
			end else if (!active_q) begin
				active_n = 1'b1;
				last_n   = stick_angle;
				total_n  = '0;
			end else if (ahead) begin
				total_n = total_add;
				last_n  = stick_angle;
			end else if (wrap) begin
				last_n = stick_angle;
			end else if (behind) begin
				active_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			last_q   <= '0;
			total_q  <= '0;
		end else begin
			active_q <= active_n;
			last_q   <= last_n;
			total_q  <= total_n;
		end
	end

	assign rotating       = active_q;
	assign degrees_turned = total_q;

endmodule
`default_nettype wire
